FILE: rtl/swhd_pkg.sv
// Shared types and constants for the sliding-window Hamming distance block.
package swhd_pkg;

  localparam int SYM_W  = 8;
  localparam int WL_W   = 6;
  localparam int DIST_W = 6;
  localparam int IDX_W  = 32;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  // Register word select (paddr above the byte offset)
  localparam logic [ADDR_W-3:0] REG_WINDOW_LENGTH = '0;

  localparam logic [WL_W-1:0] WINDOW_LENGTH_RESET = 6'd4;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             start_of_text;
  } in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  window_index;
  } out_t;

  // Per-cell control for one accepted request
  typedef struct packed {
    logic shift;    // request accepted, advance the chain
    logic capture;  // write the new symbol into this cell's reference
    logic in_win;   // this cell's age lies inside the active window
  } cell_ctrl_t;

endpackage

FILE: rtl/swhd_cell.sv
// One chain cell: a recent symbol (by age) and the reference byte it is compared with.
module swhd_cell (
  input  logic                          clk,
  input  swhd_pkg::cell_ctrl_t          ctrl,
  input  logic [swhd_pkg::SYM_W-1:0]    new_sym,
  input  logic [swhd_pkg::SYM_W-1:0]    sym_in,
  output logic [swhd_pkg::SYM_W-1:0]    sym_out,
  output logic                          mismatch
);

  logic [swhd_pkg::SYM_W-1:0] recent_r;
  logic [swhd_pkg::SYM_W-1:0] ref_r;
  logic [swhd_pkg::SYM_W-1:0] ref_nxt;

  // Shift one age step, capture reference byte when addressed
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      recent_r <= sym_in;
    end
    if (ctrl.capture) begin
      ref_r <= new_sym;
    end
  end

  // Compare against the values this request leaves behind
  assign ref_nxt  = ctrl.capture ? new_sym : ref_r;
  assign mismatch = ctrl.in_win && (sym_in != ref_nxt);
  assign sym_out  = recent_r;

endmodule

FILE: rtl/swhd_popcount.sv
// Two-level mismatch counter: registered byte-group counts, then a narrow final sum.
module swhd_popcount #(
  parameter int WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           load,
  input  logic [WIDTH-1:0]               vec_i,
  output logic [$clog2(WIDTH+1)-1:0]     sum_o
);

  localparam int NG    = (WIDTH + 7) / 8;
  localparam int PAD_W = NG * 8;
  localparam int GRP_W = 4;
  localparam int SUM_W = $clog2(WIDTH + 1);

  logic [PAD_W-1:0] vec_pad;
  logic [GRP_W-1:0] grp_nxt [NG];
  logic [GRP_W-1:0] grp_r   [NG];

  assign vec_pad = PAD_W'(vec_i);

  // Count set bits within each byte group
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp_nxt[g] = grp_nxt[g] + GRP_W'(vec_pad[g*8+b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NG; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // Final sum over the NG group counts
  always_comb begin
    sum_o = '0;
    for (int g = 0; g < NG; g++) begin
      sum_o = sum_o + SUM_W'(grp_r[g]);
    end
  end

endmodule

FILE: rtl/sliding_window_hamming_distance.sv
// Each result passes stage 1, stage 2 and the output register after its window completes.
// Throughput: one symbol per cycle unless out_stall backs up; cells update and compare in
//   the accept cycle, the count takes two register stages, an empty stage keeps input flowing.
// Reset (rst_n, synchronous, low): clears counters, valids and window_length to 4;
//   the next symbol after reset starts a new text. Cell contents are not reset.
module sliding_window_hamming_distance #(
  parameter int MAX_WINDOW = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Symbol input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  swhd_pkg::in_t                    in_data,
  // Result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output swhd_pkg::out_t                   out_data,
  // APB configuration
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [swhd_pkg::ADDR_W-1:0]      cfg_paddr,
  input  logic [swhd_pkg::DATA_W-1:0]      cfg_pwdata,
  output logic [swhd_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = $clog2(MAX_WINDOW + 1);
  localparam int ACT_RESET = (MAX_WINDOW < 4) ? MAX_WINDOW : 4;

  // Configuration
  logic [swhd_pkg::WL_W-1:0] cfg_wl_r;
  logic                      cfg_wr;

  // Text tracking
  logic [LEN_W-1:0]          seen_r, seen_nxt, eff_seen;
  logic [LEN_W-1:0]          active_r, eff_len, wl_clamp, wr_idx;
  logic [swhd_pkg::IDX_W-1:0] cnt_r, cur_idx;
  logic                      first_sym, capture, emit, accept;

  // Pipeline
  logic                      s1_valid_r, s2_valid_r, out_valid_r;
  logic [MAX_WINDOW-1:0]     s1_vec_r;
  logic [swhd_pkg::IDX_W-1:0] s1_idx_r, s2_idx_r;
  swhd_pkg::out_t            out_data_r;
  logic                      s1_ready, s2_ready, out_ready;
  logic [SUM_W-1:0]          pc_sum;

  // Cell row
  logic [swhd_pkg::SYM_W-1:0] chain [MAX_WINDOW+1];
  logic [MAX_WINDOW-1:0]      mis_vec;
  swhd_pkg::cell_ctrl_t       cell_ctrl [MAX_WINDOW];

  // APB register write and read-back
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[swhd_pkg::ADDR_W-1:2] == swhd_pkg::REG_WINDOW_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_wl_r <= swhd_pkg::WINDOW_LENGTH_RESET;
    end else if (cfg_wr) begin
      cfg_wl_r <= cfg_pwdata[swhd_pkg::WL_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[swhd_pkg::ADDR_W-1:2] == swhd_pkg::REG_WINDOW_LENGTH) begin
      cfg_prdata = swhd_pkg::DATA_W'(cfg_wl_r);
    end
  end

  // Handshake: each stage moves when its successor is empty or moving
  assign out_ready = !out_valid_r || !out_stall;
  assign s2_ready  = !s2_valid_r || out_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign accept    = in_valid && !in_stall;

  // Window length clamped to 1..MAX_WINDOW
  always_comb begin
    if (cfg_wl_r == '0) begin
      wl_clamp = LEN_W'(1);
    end else if (32'(cfg_wl_r) > 32'(MAX_WINDOW)) begin
      wl_clamp = LEN_W'(MAX_WINDOW);
    end else begin
      wl_clamp = LEN_W'(cfg_wl_r);
    end
  end

  // Per-request text bookkeeping
  always_comb begin
    eff_seen  = in_data.start_of_text ? '0 : seen_r;
    first_sym = (eff_seen == '0);
    eff_len   = first_sym ? wl_clamp : active_r;
    cur_idx   = in_data.start_of_text ? '0 : cnt_r;
    capture   = (eff_seen < eff_len);
    seen_nxt  = capture ? eff_seen + LEN_W'(1) : eff_seen;
    emit      = (seen_nxt == eff_len);
    // reference is stored by age: text position k lands in cell len-1-k
    wr_idx    = eff_len - LEN_W'(1) - eff_seen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= '0;
      active_r <= LEN_W'(ACT_RESET);
      cnt_r    <= '0;
    end else if (accept) begin
      seen_r   <= seen_nxt;
      active_r <= eff_len;
      cnt_r    <= emit ? cur_idx + 32'd1 : cur_idx;
    end
  end

  // Chain of cells, cell 0 holds the newest symbol
  assign chain[0] = in_data.symbol;

  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    always_comb begin
      cell_ctrl[j].shift   = accept;
      cell_ctrl[j].capture = accept && capture && (wr_idx == LEN_W'(j));
      cell_ctrl[j].in_win  = (LEN_W'(j) < eff_len);
    end

    swhd_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl[j]),
      .new_sym  (in_data.symbol),
      .sym_in   (chain[j]),
      .sym_out  (chain[j+1]),
      .mismatch (mis_vec[j])
    );
  end

  // Stage 1: mismatch vector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_vec_r <= mis_vec;
      s1_idx_r <= cur_idx;
    end
  end

  // Stage 2: group counts
  swhd_popcount #(
    .WIDTH (MAX_WINDOW)
  ) u_popcount (
    .clk   (clk),
    .load  (s1_valid_r && s2_ready),
    .vec_i (s1_vec_r),
    .sum_o (pc_sum)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s2_ready) begin
      s2_idx_r <= s1_idx_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && out_ready) begin
      out_data_r.distance     <= swhd_pkg::DIST_W'(pc_sum);
      out_data_r.window_index <= s2_idx_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= active_r)
    else $error("symbols seen exceeds active length");

  a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r != '0) && (32'(active_r) <= 32'(MAX_WINDOW)))
    else $error("active length out of range");

  a_emit_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept && emit |=> s1_valid_r)
    else $error("completed window did not enter stage 1");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept && emit |=> cnt_r == $past(cur_idx) + 32'd1)
    else $error("window counter did not advance");

  a_stage2_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_ready |=> s2_valid_r)
    else $error("stage 1 result lost");
`endif

endmodule

FILE: verif/swhd_distance_checker.sv
// Checker for the sliding-window Hamming distance block: predicts distances and compares results.
module swhd_distance_checker #(
  parameter int WINDOW_CAP = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  swhd_pkg::in_t                   in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  swhd_pkg::out_t                  out_data,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [swhd_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [swhd_pkg::DATA_W-1:0]     cfg_pwdata,
  input  logic                            cfg_pready,
  output int                              mismatches,
  output int                              results_pending
);

  // Shadow of the block's state
  logic [swhd_pkg::SYM_W-1:0] recent_bytes [WINDOW_CAP];
  logic [swhd_pkg::SYM_W-1:0] reference_bytes [WINDOW_CAP];
  int unsigned                symbols_in_text;
  int unsigned                active_len;
  logic [swhd_pkg::IDX_W-1:0] next_window;
  logic [swhd_pkg::WL_W-1:0]  window_length_reg;

  swhd_pkg::out_t expected_distances [$];
  swhd_pkg::out_t want;

  function automatic int unsigned clamp_len(input logic [swhd_pkg::WL_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > WINDOW_CAP) return WINDOW_CAP;
    return int'(v);
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [swhd_pkg::IDX_W-1:0] want_val,
                                 input logic [swhd_pkg::IDX_W-1:0] got_val);
    mismatches++;
    $display("%0t: %s: expected %0d, got %0d", $time, what, want_val, got_val);
  endtask

  task automatic clear_state();
    for (int k = 0; k < WINDOW_CAP; k++) begin
      recent_bytes[k] = '0;
      reference_bytes[k] = '0;
    end
    symbols_in_text = 0;
    next_window = '0;
    window_length_reg = swhd_pkg::WINDOW_LENGTH_RESET;
    active_len = clamp_len(swhd_pkg::WINDOW_LENGTH_RESET);
    expected_distances.delete();
  endtask

  // Work out the result (if any) caused by one accepted request
  task automatic predict_distance(input swhd_pkg::in_t req);
    swhd_pkg::out_t res;
    int unsigned    diff;
    if (req.start_of_text) begin
      symbols_in_text = 0;
      next_window = '0;
    end
    // length is latched at the first symbol of a text
    if (symbols_in_text == 0) active_len = clamp_len(window_length_reg);
    for (int k = 0; k < WINDOW_CAP - 1; k++) recent_bytes[k] = recent_bytes[k + 1];
    recent_bytes[WINDOW_CAP - 1] = req.symbol;
    if (symbols_in_text < active_len) begin
      reference_bytes[symbols_in_text] = req.symbol;
      symbols_in_text++;
    end
    if (symbols_in_text >= active_len) begin
      diff = 0;
      for (int k = 0; k < int'(active_len); k++) begin
        if (recent_bytes[WINDOW_CAP - active_len + k] != reference_bytes[k]) diff++;
      end
      res.distance = swhd_pkg::DIST_W'(diff);
      res.window_index = next_window;
      next_window++;
      expected_distances.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      // result side
      if (out_valid && !out_stall) begin
        if (expected_distances.size() == 0) begin
          report_mismatch("result with none expected, distance", '0,
                          swhd_pkg::IDX_W'(out_data.distance));
        end else begin
          want = expected_distances.pop_front();
          if (out_data.distance !== want.distance)
            report_mismatch("distance", swhd_pkg::IDX_W'(want.distance),
                            swhd_pkg::IDX_W'(out_data.distance));
          if (out_data.window_index !== want.window_index)
            report_mismatch("window_index", want.window_index, out_data.window_index);
        end
      end
      // symbol side uses the length held before this edge
      if (in_valid && !in_stall) predict_distance(in_data);
      // register writes; other word addresses are ignored
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[swhd_pkg::ADDR_W-1:2] == swhd_pkg::REG_WINDOW_LENGTH) begin
        window_length_reg = cfg_pwdata[swhd_pkg::WL_W-1:0];
      end
    end
    results_pending <= expected_distances.size();
  end

endmodule

FILE: verif/sliding_window_hamming_distance_test.sv
// Testbench top for the sliding-window Hamming distance block: stimulus, stalls and verdict.
module sliding_window_hamming_distance_test;

  localparam int MAX_WIN      = 32;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int NUM_PHASES   = 8;

  // Word index with no register behind it
  localparam logic [swhd_pkg::ADDR_W-3:0] REG_UNMAPPED = 1'b1;

  // Text shapes
  typedef enum int {TEXT_PERIODIC, TEXT_TWO_SYMBOL, TEXT_RANDOM} text_kind_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  swhd_pkg::in_t               in_data;
  logic                        out_valid;
  logic                        out_stall;
  swhd_pkg::out_t              out_data;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [swhd_pkg::ADDR_W-1:0] cfg_paddr;
  logic [swhd_pkg::DATA_W-1:0] cfg_pwdata;
  logic [swhd_pkg::DATA_W-1:0] cfg_prdata;
  logic                        cfg_pready;

  int mismatches;
  int results_pending;

  int unsigned idle_cycles;
  int unsigned stall_left;
  int unsigned stall_pick;
  int unsigned burst_left;

  // Text shaping state
  logic [swhd_pkg::WL_W-1:0]  written_len;
  int unsigned                text_len;
  int unsigned                text_pos;
  int unsigned                text_left;
  text_kind_t                 text_kind;
  logic [swhd_pkg::SYM_W-1:0] pattern [MAX_WIN];
  logic [swhd_pkg::SYM_W-1:0] sym_a;
  logic [swhd_pkg::SYM_W-1:0] sym_b;

  sliding_window_hamming_distance #(.MAX_WINDOW(MAX_WIN)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  swhd_distance_checker #(.WINDOW_CAP(MAX_WIN)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_pready      (cfg_pready),
    .mismatches      (mismatches),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result-side back-pressure: short stalls, a few long ones, some stall-free stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(1, 8);
      end else if (stall_pick < 60) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(30, 80);
      end else if (stall_pick < 93) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end else begin
      stall_left--;
    end
  end

  // Watchdog: too long without an accepted symbol, a taken result or a register access ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Gap before the next symbol; mostly none, sometimes long, with idle-free bursts
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_symbol(input logic [swhd_pkg::SYM_W-1:0] sym, input logic sot);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{symbol: sym, start_of_text: sot};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Let every expected result arrive, then give the pipeline time to empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [swhd_pkg::ADDR_W-3:0] word,
                           input logic [swhd_pkg::DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {word, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Upper data bits are junk; only the low six bits matter
  task automatic set_window_length(input logic [swhd_pkg::WL_W-1:0] len);
    wait_idle();
    write_reg(swhd_pkg::REG_WINDOW_LENGTH, ($urandom() & ~32'h3F) | swhd_pkg::DATA_W'(len));
    written_len = len;
  endtask

  task automatic begin_text();
    int unsigned r;
    text_len = (written_len == '0) ? 1 :
               (int'(written_len) > MAX_WIN ? MAX_WIN : int'(written_len));
    sym_a = swhd_pkg::SYM_W'($urandom_range(0, 255));
    sym_b = ~sym_a;
    r = $urandom_range(0, 99);
    if (r < 50) text_kind = TEXT_PERIODIC;
    else if (r < 80) text_kind = TEXT_TWO_SYMBOL;
    else text_kind = TEXT_RANDOM;
    for (int k = 0; k < MAX_WIN; k++) begin
      pattern[k] = ($urandom_range(0, 1) == 1) ? sym_a : sym_b;
      if ($urandom_range(0, 3) == 0) pattern[k] = swhd_pkg::SYM_W'($urandom_range(0, 255));
    end
    // some texts end before the first window is complete
    if (text_len > 1 && $urandom_range(0, 99) < 15) text_left = $urandom_range(1, text_len - 1);
    else text_left = $urandom_range(text_len, 3 * text_len + 8);
    text_pos = 0;
  endtask

  function automatic logic [swhd_pkg::SYM_W-1:0] next_symbol();
    unique case (text_kind)
      TEXT_PERIODIC: begin
        if (text_pos >= text_len && $urandom_range(0, 9) == 0)
          return swhd_pkg::SYM_W'($urandom_range(0, 255));
        return pattern[text_pos % text_len];
      end
      TEXT_TWO_SYMBOL: begin
        return ($urandom_range(0, 1) == 1) ? sym_a : sym_b;
      end
      default: begin
        return swhd_pkg::SYM_W'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // Texts continue across phase boundaries, so a new length waits for the next start
  task automatic run_texts(input int unsigned count);
    logic sot;
    repeat (count) begin
      sot = 1'b0;
      if (text_left == 0) begin
        begin_text();
        sot = 1'b1;
      end
      send_symbol(next_symbol(), sot);
      text_left--;
      text_pos++;
    end
  endtask

  initial begin
    logic [swhd_pkg::WL_W-1:0] phase_len [NUM_PHASES];
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    burst_left  = 0;
    text_left   = 0;
    written_len = swhd_pkg::WINDOW_LENGTH_RESET;
    rst_n       = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First text after reset carries no start marker
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'hA5, 1'b0);
    send_symbol(8'h5A, 1'b0);
    // text shorter than the window
    send_symbol(8'h01, 1'b1);
    send_symbol(8'h02, 1'b0);
    // every position mismatching once the zeros fill the window
    send_symbol(8'hFF, 1'b1);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'h00, 1'b0);
    // one-symbol text followed directly by another start
    send_symbol(8'h33, 1'b1);
    send_symbol(8'hC3, 1'b1);
    send_symbol(8'h3C, 1'b0);
    send_symbol(8'hC3, 1'b0);
    send_symbol(8'h3C, 1'b0);
    send_symbol(8'hC3, 1'b0);

    // write to a word with no register behind it; must change nothing
    wait_idle();
    write_reg(REG_UNMAPPED, 32'hFFFF_FFC1);

    // Random phases, extremes and out-of-range lengths first
    phase_len[0] = 6'd0;
    phase_len[1] = 6'd1;
    phase_len[2] = 6'd32;
    phase_len[3] = 6'd63;
    phase_len[4] = 6'd33;
    phase_len[5] = 6'd5;
    phase_len[6] = swhd_pkg::WL_W'($urandom_range(2, 31));
    phase_len[7] = swhd_pkg::WL_W'($urandom_range(0, 63));
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_window_length(phase_len[p]);
      run_texts(PHASE_ITEMS);
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
